// ----- design/linked_block_pool_allocator_defines.svh -----
// Assertion helpers used by the allocator sequencer.
// Both sample on clk and are switched off while rst is high.
`ifndef LINKED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define LINKED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define LBPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LBPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lbpa_pkg.sv -----
package lbpa_pkg;

  // Pool geometry
  localparam int POOL_BLOCKS = 64;
  localparam int IDX_W       = $clog2(POOL_BLOCKS);
  localparam int LINK_W      = IDX_W + 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  // Link value meaning "no block"
  localparam link_t LINK_NONE = LINK_W'(POOL_BLOCKS);
  localparam idx_t  LAST_IDX  = IDX_W'(POOL_BLOCKS - 1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_ALLOC      = 2'd0,
    REQ_FREE_ONE   = 2'd1,
    REQ_FREE_CHAIN = 2'd2
  } req_t;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A0,
    S_A1,
    S_A2,
    S_A3,
    S_C0,
    S_C1,
    S_R0,
    S_R1,
    S_R2,
    S_R3,
    S_DONE
  } state_t;

  // Link memory commands for one cycle
  typedef struct packed {
    logic  nxt_we;
    idx_t  nxt_waddr;
    link_t nxt_wdata;
    idx_t  nxt_raddr;
    logic  prv_we;
    idx_t  prv_waddr;
    link_t prv_wdata;
    idx_t  prv_raddr;
  } mem_cmd_t;

  // Finished transaction from the sequencer
  typedef struct packed {
    logic  done;
    link_t index;
    logic  status;
  } rsp_t;

  function automatic logic is_block(link_t l);
    return l < LINK_NONE;
  endfunction

endpackage

// ----- design/lbpa_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle
module lbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lbpa_ctrl.sv -----
`include "linked_block_pool_allocator_defines.svh"

// Sequencer: runs every request as a series of link memory steps.
// The unlink/relink step sequence is shared by single free and chain free.
module lbpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_type,
  input  logic [5:0]        block_index,
  output logic              req_stall,
  input  logic              out_free,
  input  lbpa_pkg::link_t   nxt_rdata,
  input  lbpa_pkg::link_t   prv_rdata,
  output lbpa_pkg::mem_cmd_t cmd,
  output lbpa_pkg::rsp_t    rsp
);

  lbpa_pkg::state_t state, state_next;
  lbpa_pkg::idx_t   blk, blk_next;
  lbpa_pkg::idx_t   clr_idx, clr_idx_next;
  lbpa_pkg::link_t  free_head, free_head_next;
  lbpa_pkg::link_t  link_p, link_p_next;
  lbpa_pkg::link_t  link_n, link_n_next;
  lbpa_pkg::link_t  chain_p, chain_p_next;
  lbpa_pkg::link_t  cnt, cnt_next;
  lbpa_pkg::link_t  cnt_inc;
  logic             chain, chain_next;
  lbpa_pkg::link_t  res_index, res_index_next;
  logic             res_status, res_status_next;

  assign req_stall = (state != lbpa_pkg::S_IDLE);
  assign cnt_inc   = cnt + 1'b1;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lbpa_pkg::S_CLEAR;
      clr_idx   <= '0;
      free_head <= '0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      free_head <= free_head_next;
      cnt       <= cnt_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    blk        <= blk_next;
    link_p     <= link_p_next;
    link_n     <= link_n_next;
    chain_p    <= chain_p_next;
    chain      <= chain_next;
    res_index  <= res_index_next;
    res_status <= res_status_next;
  end

  // Next state and memory commands
  always_comb begin
    state_next      = state;
    blk_next        = blk;
    clr_idx_next    = clr_idx;
    free_head_next  = free_head;
    link_p_next     = link_p;
    link_n_next     = link_n;
    chain_p_next    = chain_p;
    cnt_next        = cnt;
    chain_next      = chain;
    res_index_next  = res_index;
    res_status_next = res_status;
    cmd             = '0;
    rsp.done        = 1'b0;
    rsp.index       = res_index;
    rsp.status      = res_status;

    unique case (state)
      // Build the initial free list, one entry per cycle
      lbpa_pkg::S_CLEAR: begin
        cmd.nxt_we    = 1'b1;
        cmd.nxt_waddr = clr_idx;
        cmd.nxt_wdata = lbpa_pkg::LINK_W'(clr_idx) + 1'b1;
        cmd.prv_we    = 1'b1;
        cmd.prv_waddr = clr_idx;
        cmd.prv_wdata = (clr_idx == '0) ? lbpa_pkg::LINK_NONE
                                        : lbpa_pkg::LINK_W'(clr_idx) - 1'b1;
        clr_idx_next  = clr_idx + 1'b1;
        if (clr_idx == lbpa_pkg::LAST_IDX) begin
          state_next = lbpa_pkg::S_IDLE;
        end
      end

      lbpa_pkg::S_IDLE: begin
        if (req_valid) begin
          blk_next        = block_index;
          res_index_next  = lbpa_pkg::LINK_NONE;
          res_status_next = lbpa_pkg::STATUS_OK;
          unique case (req_type)
            lbpa_pkg::REQ_ALLOC: begin
              if (!lbpa_pkg::is_block(free_head)) begin
                res_status_next = lbpa_pkg::STATUS_EMPTY;
                state_next      = lbpa_pkg::S_DONE;
              end else begin
                link_p_next = free_head;
                state_next  = lbpa_pkg::S_A0;
              end
            end
            lbpa_pkg::REQ_FREE_ONE: begin
              chain_next = 1'b0;
              state_next = lbpa_pkg::S_R0;
            end
            lbpa_pkg::REQ_FREE_CHAIN: begin
              chain_next = 1'b1;
              state_next = lbpa_pkg::S_C0;
            end
            default: begin
              state_next = lbpa_pkg::S_DONE;
            end
          endcase
        end
      end

      // Allocate: fetch successor of the free head
      lbpa_pkg::S_A0: begin
        cmd.nxt_raddr = link_p[lbpa_pkg::IDX_W-1:0];
        state_next    = lbpa_pkg::S_A1;
      end

      // Advance free head, cut its back link; fetch successor of target
      lbpa_pkg::S_A1: begin
        free_head_next = nxt_rdata;
        cmd.nxt_raddr  = blk;
        if (lbpa_pkg::is_block(nxt_rdata)) begin
          cmd.prv_we    = 1'b1;
          cmd.prv_waddr = nxt_rdata[lbpa_pkg::IDX_W-1:0];
          cmd.prv_wdata = lbpa_pkg::LINK_NONE;
        end
        state_next = lbpa_pkg::S_A2;
      end

      // Link new block between target and its old successor
      lbpa_pkg::S_A2: begin
        link_n_next   = nxt_rdata;
        cmd.prv_we    = 1'b1;
        cmd.prv_waddr = link_p[lbpa_pkg::IDX_W-1:0];
        cmd.prv_wdata = lbpa_pkg::LINK_W'(blk);
        cmd.nxt_we    = 1'b1;
        cmd.nxt_waddr = link_p[lbpa_pkg::IDX_W-1:0];
        cmd.nxt_wdata = nxt_rdata;
        state_next    = lbpa_pkg::S_A3;
      end

      lbpa_pkg::S_A3: begin
        if (lbpa_pkg::is_block(link_n)) begin
          cmd.prv_we    = 1'b1;
          cmd.prv_waddr = link_n[lbpa_pkg::IDX_W-1:0];
          cmd.prv_wdata = link_p;
        end
        cmd.nxt_we     = 1'b1;
        cmd.nxt_waddr  = blk;
        cmd.nxt_wdata  = link_p;
        res_index_next = link_p;
        state_next     = lbpa_pkg::S_DONE;
      end

      // Chain free: detach from predecessor
      lbpa_pkg::S_C0: begin
        cmd.prv_raddr = blk;
        state_next    = lbpa_pkg::S_C1;
      end

      lbpa_pkg::S_C1: begin
        chain_p_next = prv_rdata;
        if (lbpa_pkg::is_block(prv_rdata)) begin
          cmd.nxt_we    = 1'b1;
          cmd.nxt_waddr = prv_rdata[lbpa_pkg::IDX_W-1:0];
          cmd.nxt_wdata = lbpa_pkg::LINK_NONE;
        end
        cnt_next   = '0;
        state_next = lbpa_pkg::S_R0;
      end

      // Release: read both links of the block
      lbpa_pkg::S_R0: begin
        cmd.nxt_raddr = blk;
        cmd.prv_raddr = blk;
        state_next    = lbpa_pkg::S_R1;
      end

      // Release: bridge the neighbours
      lbpa_pkg::S_R1: begin
        link_p_next = prv_rdata;
        link_n_next = nxt_rdata;
        if (lbpa_pkg::is_block(prv_rdata)) begin
          cmd.nxt_we    = 1'b1;
          cmd.nxt_waddr = prv_rdata[lbpa_pkg::IDX_W-1:0];
          cmd.nxt_wdata = nxt_rdata;
        end
        if (lbpa_pkg::is_block(nxt_rdata)) begin
          cmd.prv_we    = 1'b1;
          cmd.prv_waddr = nxt_rdata[lbpa_pkg::IDX_W-1:0];
          cmd.prv_wdata = prv_rdata;
        end
        state_next = lbpa_pkg::S_R2;
      end

      // Release: push block on the free list
      lbpa_pkg::S_R2: begin
        cmd.nxt_we    = 1'b1;
        cmd.nxt_waddr = blk;
        cmd.nxt_wdata = free_head;
        cmd.prv_we    = 1'b1;
        cmd.prv_waddr = blk;
        cmd.prv_wdata = lbpa_pkg::LINK_NONE;
        state_next    = lbpa_pkg::S_R3;
      end

      // Release: back link of old free head, then continue or finish
      lbpa_pkg::S_R3: begin
        if (lbpa_pkg::is_block(free_head)) begin
          cmd.prv_we    = 1'b1;
          cmd.prv_waddr = free_head[lbpa_pkg::IDX_W-1:0];
          cmd.prv_wdata = lbpa_pkg::LINK_W'(blk);
        end
        free_head_next = lbpa_pkg::LINK_W'(blk);
        if (!chain) begin
          res_index_next = link_n;
          state_next     = lbpa_pkg::S_DONE;
        end else begin
          cnt_next = cnt_inc;
          if (lbpa_pkg::is_block(link_n) && (cnt_inc < lbpa_pkg::LINK_NONE)) begin
            blk_next   = link_n[lbpa_pkg::IDX_W-1:0];
            state_next = lbpa_pkg::S_R0;
          end else begin
            res_index_next = chain_p;
            state_next     = lbpa_pkg::S_DONE;
          end
        end
      end

      // Hand the result over once the output slot is free
      lbpa_pkg::S_DONE: begin
        if (out_free) begin
          rsp.done   = 1'b1;
          state_next = lbpa_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lbpa_pkg::S_IDLE;
      end
    endcase
  end

  `LBPA_ASSERT_IMP(a_fh_range, state != lbpa_pkg::S_CLEAR, free_head <= lbpa_pkg::LINK_NONE, "free head out of range")
  `LBPA_ASSERT_IMP(a_walk_bound, 1'b1, cnt <= lbpa_pkg::LINK_NONE, "chain walk exceeded pool size")
  `LBPA_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, state != lbpa_pkg::S_IDLE, "accepted transaction lost")
  `LBPA_ASSERT_IMP(a_done_slot, rsp.done, out_free, "result issued into a full output slot")

endmodule

// ----- design/linked_block_pool_allocator.sv -----
// Pool of 64 blocks with next and previous links held in two link RAMs;
// free blocks form a doubly linked list. After reset the block runs a
// clearing pass that chains every block onto the free list, holding
// req_stall high meanwhile. One request is handled at a time by a
// sequencer issuing one read and one write per link RAM per cycle, so
// the RAM ports set the pace of each request. A chain free releases at
// most 64 blocks. The result sits in an output register, so a request can
// be accepted while the previous result is still waiting on rsp_stall.
module linked_block_pool_allocator (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] req_type,
  input  logic [5:0] block_index,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [6:0] result_index,
  output logic       status
);

  lbpa_pkg::mem_cmd_t cmd;
  lbpa_pkg::rsp_t     rsp;
  lbpa_pkg::link_t    nxt_rdata;
  lbpa_pkg::link_t    prv_rdata;
  logic               out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  lbpa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_type    (req_type),
    .block_index (block_index),
    .req_stall   (req_stall),
    .out_free    (out_free),
    .nxt_rdata   (nxt_rdata),
    .prv_rdata   (prv_rdata),
    .cmd         (cmd),
    .rsp         (rsp)
  );

  // Next links
  lbpa_ram #(
    .WIDTH (lbpa_pkg::LINK_W),
    .DEPTH (lbpa_pkg::POOL_BLOCKS)
  ) u_nxt_ram (
    .clk   (clk),
    .we    (cmd.nxt_we),
    .waddr (cmd.nxt_waddr),
    .wdata (cmd.nxt_wdata),
    .raddr (cmd.nxt_raddr),
    .rdata (nxt_rdata)
  );

  // Previous links
  lbpa_ram #(
    .WIDTH (lbpa_pkg::LINK_W),
    .DEPTH (lbpa_pkg::POOL_BLOCKS)
  ) u_prv_ram (
    .clk   (clk),
    .we    (cmd.prv_we),
    .waddr (cmd.prv_waddr),
    .wdata (cmd.prv_wdata),
    .raddr (cmd.prv_raddr),
    .rdata (prv_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp.done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done) begin
      result_index <= rsp.index;
      status       <= rsp.status;
    end
  end

endmodule

// ----- bench/lbpa_link_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the allocator, keeps its own copy of the link
// tables and the free list, and compares every result with the answer due.
module lbpa_link_checker
  import lbpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_stall,
  input  logic [1:0] req_type,
  input  logic [5:0] block_index,
  input  logic       rsp_valid,
  input  logic       rsp_stall,
  input  logic [6:0] result_index,
  input  logic       status,
  output int         fail_count,
  output int         pending,
  output int         empty_seen
);

  // One answer owed by the block, with the request that caused it
  typedef struct packed {
    logic [1:0] kind;
    idx_t       blk;
    link_t      index;
    logic       status;
  } answer_t;

  link_t   nxt_tab [POOL_BLOCKS];
  link_t   prv_tab [POOL_BLOCKS];
  link_t   free_top;
  answer_t due_answers [$];
  int      misses = 0;
  int      empties = 0;

  function automatic bit in_pool(link_t l);
    return l < LINK_NONE;
  endfunction

  function automatic idx_t slot(link_t l);
    return l[IDX_W-1:0];
  endfunction

  // Unlink one block from its neighbours and push it onto the free list
  function automatic link_t return_to_pool(idx_t b);
    link_t p;
    link_t n;
    p = prv_tab[b];
    n = nxt_tab[b];
    if (in_pool(p)) nxt_tab[slot(p)] = n;
    if (in_pool(n)) prv_tab[slot(n)] = p;
    prv_tab[b] = LINK_NONE;
    nxt_tab[b] = free_top;
    if (in_pool(free_top)) prv_tab[slot(free_top)] = link_t'(b);
    free_top = link_t'(b);
    return n;
  endfunction

  // Apply one request to the shadow tables and work out its answer
  function automatic answer_t apply_request(logic [1:0] rq, idx_t b);
    answer_t a;
    link_t   nb;
    link_t   succ;
    link_t   p;
    link_t   cur;
    int      walked;
    a.kind   = rq;
    a.blk    = b;
    a.index  = LINK_NONE;
    a.status = STATUS_OK;
    case (rq)
      REQ_ALLOC: begin
        nb = free_top;
        if (!in_pool(nb)) begin
          a.status = STATUS_EMPTY;
        end else begin
          free_top = nxt_tab[slot(nb)];
          if (in_pool(free_top)) prv_tab[slot(free_top)] = LINK_NONE;
          succ = nxt_tab[b];
          prv_tab[slot(nb)] = link_t'(b);
          nxt_tab[slot(nb)] = succ;
          if (in_pool(succ)) prv_tab[slot(succ)] = nb;
          nxt_tab[b] = nb;
          a.index = nb;
        end
      end
      REQ_FREE_ONE: begin
        a.index = return_to_pool(b);
      end
      REQ_FREE_CHAIN: begin
        // detach from the predecessor, then release the rest; a loop in
        // the links stops after one pass over the pool
        p = prv_tab[b];
        if (in_pool(p)) nxt_tab[slot(p)] = LINK_NONE;
        cur = link_t'(b);
        walked = 0;
        while (in_pool(cur) && walked < POOL_BLOCKS) begin
          cur = return_to_pool(slot(cur));
          walked++;
        end
        a.index = p;
      end
      default: ;
    endcase
    return a;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < POOL_BLOCKS; i++) begin
        nxt_tab[i] = link_t'(i + 1);
        prv_tab[i] = (i == 0) ? LINK_NONE : link_t'(i - 1);
      end
      free_top = '0;
      due_answers.delete();
    end else begin
      if (req_valid && !req_stall)
        due_answers.push_back(apply_request(req_type, block_index));
      if (rsp_valid && !rsp_stall) begin
        if (status == STATUS_EMPTY) empties++;
        if (due_answers.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("%0t: result index %0d status %0d arrived with nothing outstanding",
                     $realtime, result_index, status);
        end else begin
          want = due_answers.pop_front();
          if (want.index !== result_index || want.status !== status) begin
            misses++;
            if (misses <= 10)
              $display("%0t: req %0d blk %0d: expected index %0d status %0d, got %0d %0d",
                       $realtime, want.kind, want.blk, want.index, want.status,
                       result_index, status);
          end
        end
      end
    end
    fail_count <= misses;
    pending    <= due_answers.size();
    empty_seen <= empties;
  end

endmodule

// ----- bench/linked_block_pool_allocator_tb.sv -----
`timescale 1ns / 100ps

module linked_block_pool_allocator_tb;
  import lbpa_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 1650;
  localparam int HANG_LIMIT   = 4000;  // longer than the longest chain free
  localparam int TAIL_CYCLES  = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] req_type = REQ_ALLOC;
  logic [5:0] block_index = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [6:0] result_index;
  logic       status;

  int fail_count;
  int pending;
  int empty_seen;

  bit         calm = 1'b0;       // no idling on either side while set
  int         stall_left = 0;
  int         idle_cycles = 0;
  int         results_seen = 0;
  int         made = 0;
  int         kind_count [4] = '{0, 0, 0, 0};
  logic [1:0] sent_kind [$];     // request kinds in order of acceptance
  logic [5:0] live_q [$];        // blocks believed to be allocated

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  linked_block_pool_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .block_index  (block_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_index (result_index),
    .status       (status)
  );

  lbpa_link_checker pool_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .block_index  (block_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_index (result_index),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending),
    .empty_seen   (empty_seen)
  );

  // Result side: random stall per result, and note blocks handed out
  always @(posedge clk) begin
    logic [1:0] kind;
    if (rsp_valid && !rsp_stall) begin
      if (!rst) begin
        results_seen++;
        kind = sent_kind.pop_front();
        if (kind == REQ_ALLOC && status == STATUS_OK && result_index < LINK_NONE) begin
          live_q.push_back(result_index[5:0]);
          if (live_q.size() > 96) void'(live_q.pop_front());
        end
      end
      stall_left = calm ? 0 : $urandom_range(0, 5);
      rsp_stall <= (stall_left != 0);
    end else if (rsp_valid && stall_left > 0) begin
      stall_left--;
      rsp_stall <= (stall_left != 0);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drive one request after a random gap and wait for it to be taken
  task automatic issue(logic [1:0] rq, logic [5:0] blk);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= rq;
    block_index <= blk;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_kind.push_back(rq);
    kind_count[rq]++;
  endtask

  function automatic logic [5:0] take_live(bit remove);
    int k;
    logic [5:0] b;
    k = $urandom_range(0, live_q.size() - 1);
    b = live_q[k];
    if (remove) live_q.delete(k);
    return b;
  endfunction

  // mode 0 fills the pool, 1 mostly grows chains, 2 mostly shrinks them
  task automatic random_item(int mode);
    int         roll;
    logic [1:0] rq;
    logic [5:0] blk;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      rq  = 2'($urandom_range(0, 3));
      blk = 6'($urandom_range(0, 63));
    end else if (live_q.size() == 0) begin
      rq  = REQ_ALLOC;
      blk = 6'($urandom_range(0, 63));
    end else if (mode == 0 || (mode == 1 && roll < 75) || (mode == 2 && roll < 30)) begin
      rq  = REQ_ALLOC;
      blk = take_live(1'b0);
    end else if (roll < ((mode == 1) ? 92 : 80)) begin
      rq  = REQ_FREE_ONE;
      blk = take_live(1'b1);
    end else begin
      rq  = REQ_FREE_CHAIN;
      blk = take_live(1'b1);
    end
    issue(rq, blk);
    made++;
  endtask

  // Hold the sender until every answer has come back
  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase_len;
    int phase_no;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: end blocks, inserts with and without a successor, every
    // request kind, unknown kind, freeing a free block, chain frees
    issue(REQ_ALLOC, 6'd63);
    issue(REQ_ALLOC, 6'd0);
    issue(REQ_ALLOC, 6'd0);
    issue(REQ_FREE_ONE, 6'd2);
    issue(REQ_UNKNOWN, 6'd63);
    issue(REQ_UNKNOWN, 6'd0);
    issue(REQ_FREE_ONE, 6'd63);
    issue(REQ_ALLOC, 6'd1);
    issue(REQ_ALLOC, 6'd1);
    issue(REQ_FREE_CHAIN, 6'd1);
    issue(REQ_ALLOC, 6'd42);
    issue(REQ_ALLOC, 6'd21);
    issue(REQ_FREE_CHAIN, 6'd0);
    issue(REQ_FREE_ONE, 6'd42);
    drain();

    // Fill until the pool runs dry, then alternate growing and shrinking
    repeat (80) random_item(0);
    phase_no = 0;
    while (made < RANDOM_ITEMS) begin
      phase_len = $urandom_range(60, 150);
      if (phase_len > RANDOM_ITEMS - made) phase_len = RANDOM_ITEMS - made;
      calm = ($urandom_range(0, 3) == 0);
      repeat (phase_len) random_item($urandom_range(1, 2));
      phase_no++;
      if (phase_no % 3 == 0) drain();
    end
    calm = 1'b0;

    // Let the last answers arrive, then run an idle tail
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d allocate, %0d single free, %0d chain free,",
             kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
             kind_count[REQ_ALLOC], kind_count[REQ_FREE_ONE], kind_count[REQ_FREE_CHAIN]);
    $display("%0d unknown; %0d results compared, %0d of them reported an empty pool.",
             kind_count[REQ_UNKNOWN], results_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
